>>> src/arma_pkg.sv
// ============================================================================
// ARMA predictor package
// Shared widths, codes, command/status types and fixed-point helpers.
// ============================================================================
package arma_pkg;

    localparam int MAX_ORDER_DEF = 3;
    localparam int NUM_TAPS      = 3;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int PRED_W     = 20;
    localparam int SUM_W      = 48;
    localparam int ORDER_W    = 2;
    localparam int TAP_W      = 2;
    localparam int STEP_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FRAC_W    = 12;
    localparam int ACC_W     = 38;
    localparam int RND_W     = ACC_W - FRAC_W;
    localparam int MUL_W     = 21;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int SQ_W      = 40;
    localparam int SAT_IN_W  = 27;
    localparam int OUT_RAW_W = 3 * PRED_W + SUM_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AR_ORDER  = 3'd0,
        CFG_MA_ORDER  = 3'd1,
        CFG_AR_COEF_A = 3'd2,
        CFG_AR_COEF_B = 3'd3,
        CFG_AR_COEF_C = 3'd4,
        CFG_MA_COEF_A = 3'd5,
        CFG_MA_COEF_B = 3'd6,
        CFG_MA_COEF_C = 3'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_AR,
        OP_MA,
        OP_SQ
    } t_mul_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_MA_LAST,
        S_FIN,
        S_SQ,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic             start;
        t_mul_op          op;
        logic [TAP_W-1:0] tap;
        logic             acc_ar_en;
        logic             acc_ma_en;
        logic             ar_latch;
        logic             fin_latch;
        logic             commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_status;

    // round half up from Q.12 to integer
    function automatic logic signed [RND_W-1:0] round_q12(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = a + ACC_W'(signed'(2048));
        return t[ACC_W-1:FRAC_W];
    endfunction

    function automatic logic signed [PRED_W-1:0] sat_pred(input logic signed [SAT_IN_W-1:0] v);
        logic signed [SAT_IN_W-1:0] hi;
        logic signed [SAT_IN_W-1:0] lo;
        hi = SAT_IN_W'(signed'(524287));
        lo = -SAT_IN_W'(signed'(524288));
        if (v > hi) begin
            return hi[PRED_W-1:0];
        end else if (v < lo) begin
            return lo[PRED_W-1:0];
        end
        return v[PRED_W-1:0];
    endfunction

endpackage

>>> src/arma_ctrl.sv
// ============================================================================
// ARMA predictor controller
// Sequences the shared multiplier over AR taps, MA taps and the squared error.
// ============================================================================
module arma_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  arma_pkg::t_dp_status i_status,
    output arma_pkg::t_dp_cmd    o_cmd
);

    arma_pkg::t_state               r_state;
    arma_pkg::t_state               n_state;
    logic [arma_pkg::STEP_W-1:0]    r_step;
    logic [arma_pkg::STEP_W-1:0]    n_step;

    localparam logic [arma_pkg::STEP_W-1:0] TapsStep = arma_pkg::STEP_W'(arma_pkg::NUM_TAPS);
    localparam logic [arma_pkg::STEP_W-1:0] LastStep =
        arma_pkg::STEP_W'(2 * arma_pkg::NUM_TAPS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arma_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            arma_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.start = 1'b1;
                    n_step      = '0;
                    n_state     = arma_pkg::S_MAC;
                end
            end
            arma_pkg::S_MAC: begin
                if (r_step < TapsStep) begin
                    o_cmd.op        = arma_pkg::OP_AR;
                    o_cmd.tap       = r_step[arma_pkg::TAP_W-1:0];
                    o_cmd.acc_ar_en = (r_step != '0);
                end else begin
                    o_cmd.op        = arma_pkg::OP_MA;
                    o_cmd.tap       = arma_pkg::TAP_W'(r_step - TapsStep);
                    o_cmd.acc_ar_en = (r_step == TapsStep);
                    o_cmd.acc_ma_en = (r_step != TapsStep);
                    o_cmd.ar_latch  = (r_step == TapsStep + 1'b1);
                end
                if (r_step == LastStep) begin
                    n_state = arma_pkg::S_MA_LAST;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            arma_pkg::S_MA_LAST: begin
                o_cmd.acc_ma_en = 1'b1;
                n_state         = arma_pkg::S_FIN;
            end
            arma_pkg::S_FIN: begin
                o_cmd.fin_latch = 1'b1;
                n_state         = arma_pkg::S_SQ;
            end
            arma_pkg::S_SQ: begin
                o_cmd.op = arma_pkg::OP_SQ;
                n_state  = arma_pkg::S_COMMIT;
            end
            arma_pkg::S_COMMIT: begin
                // hold the square until the output register frees up
                o_cmd.op = arma_pkg::OP_SQ;
                if (!i_status.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = arma_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = arma_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> src/arma_dp.sv
// ============================================================================
// ARMA predictor datapath
// Config registers, histories, shared multiplier, accumulators, output stage.
// ============================================================================
module arma_dp #(
    parameter int MAX_ORDER = arma_pkg::MAX_ORDER_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [arma_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [arma_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  arma_pkg::t_dp_cmd                      i_cmd,
    output arma_pkg::t_dp_status                   o_status,
    input  logic signed [arma_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                                   i_first,
    input  logic                                   i_m_tready,
    output logic                                   o_m_tvalid,
    output logic [arma_pkg::OUT_W-1:0]             o_m_tdata
);

    localparam int SW  = arma_pkg::SAMPLE_W;
    localparam int CW  = arma_pkg::COEF_W;
    localparam int PW  = arma_pkg::PRED_W;
    localparam int AW  = arma_pkg::ACC_W;
    localparam int MW  = arma_pkg::MUL_W;
    localparam int QW  = arma_pkg::SAT_IN_W;
    localparam int TW  = arma_pkg::SUM_W;

    logic [arma_pkg::ORDER_W-1:0]  r_ar_order;
    logic [arma_pkg::ORDER_W-1:0]  r_ma_order;
    logic signed [CW-1:0]          r_ar_coef [arma_pkg::NUM_TAPS];
    logic signed [CW-1:0]          r_ma_coef [arma_pkg::NUM_TAPS];

    logic signed [SW-1:0]          r_samp_hist [MAX_ORDER];
    logic signed [PW-1:0]          r_res_hist  [MAX_ORDER];
    logic [TW-1:0]                 r_total;
    logic [TW-1:0]                 n_total;

    logic signed [SW-1:0]          r_x;
    logic                          r_first;
    logic signed [AW-1:0]          r_acc_ar;
    logic signed [AW-1:0]          r_acc_ma;
    logic signed [arma_pkg::PROD_W-1:0] r_prod;
    logic signed [arma_pkg::PROD_W-1:0] n_prod;
    logic signed [PW-1:0]          r_ar_pred;
    logic signed [PW-1:0]          r_resid;
    logic signed [PW-1:0]          r_fin;
    logic signed [MW-1:0]          r_diff;
    logic                          r_out_valid;
    logic [arma_pkg::OUT_W-1:0]    r_out_data;

    logic signed [SW-1:0]          samp_sel;
    logic signed [PW-1:0]          res_sel;
    logic signed [CW-1:0]          ar_coef_sel;
    logic signed [CW-1:0]          ma_coef_sel;
    logic signed [MW-1:0]          mul_a;
    logic signed [MW-1:0]          mul_b;
    logic                          tap_used;

    logic signed [PW-1:0]          ar_val;
    logic signed [PW-1:0]          resid_val;
    logic signed [PW-1:0]          fin_val;
    logic signed [arma_pkg::RND_W-1:0] ar_rnd;
    logic signed [arma_pkg::RND_W-1:0] ma_rnd;
    logic [arma_pkg::SQ_W-1:0]     sq;
    logic [TW:0]                   total_sum;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ar_order <= arma_pkg::ORDER_W'(1);
            r_ma_order <= arma_pkg::ORDER_W'(1);
            for (int i = 0; i < arma_pkg::NUM_TAPS; i++) begin
                r_ar_coef[i] <= '0;
                r_ma_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (arma_pkg::t_cfg_reg'(i_cfg_idx))
                arma_pkg::CFG_AR_ORDER:  r_ar_order   <= i_cfg_data[arma_pkg::ORDER_W-1:0];
                arma_pkg::CFG_MA_ORDER:  r_ma_order   <= i_cfg_data[arma_pkg::ORDER_W-1:0];
                arma_pkg::CFG_AR_COEF_A: r_ar_coef[0] <= i_cfg_data;
                arma_pkg::CFG_AR_COEF_B: r_ar_coef[1] <= i_cfg_data;
                arma_pkg::CFG_AR_COEF_C: r_ar_coef[2] <= i_cfg_data;
                arma_pkg::CFG_MA_COEF_A: r_ma_coef[0] <= i_cfg_data;
                arma_pkg::CFG_MA_COEF_B: r_ma_coef[1] <= i_cfg_data;
                arma_pkg::CFG_MA_COEF_C: r_ma_coef[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // operand select
    always_comb begin
        samp_sel    = '0;
        res_sel     = '0;
        ar_coef_sel = '0;
        ma_coef_sel = '0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            if (i_cmd.tap == arma_pkg::TAP_W'(i)) begin
                samp_sel = r_samp_hist[i];
                res_sel  = r_res_hist[i];
            end
        end
        for (int i = 0; i < arma_pkg::NUM_TAPS; i++) begin
            if (i_cmd.tap == arma_pkg::TAP_W'(i)) begin
                ar_coef_sel = r_ar_coef[i];
                ma_coef_sel = r_ma_coef[i];
            end
        end
        mul_a    = '0;
        mul_b    = '0;
        tap_used = 1'b0;
        case (i_cmd.op)
            arma_pkg::OP_AR: begin
                mul_a    = MW'(samp_sel);
                mul_b    = MW'(ar_coef_sel);
                tap_used = (i_cmd.tap < r_ar_order);
            end
            arma_pkg::OP_MA: begin
                mul_a    = MW'(res_sel);
                mul_b    = MW'(ma_coef_sel);
                tap_used = (i_cmd.tap < r_ma_order);
            end
            arma_pkg::OP_SQ: begin
                mul_a    = r_diff;
                mul_b    = r_diff;
                tap_used = 1'b1;
            end
            default: ;
        endcase
        n_prod = '0;
        if (tap_used) begin
            n_prod = mul_a * mul_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    // rounding, saturation and error terms
    always_comb begin
        ar_rnd    = arma_pkg::round_q12(r_acc_ar);
        ar_val    = r_first ? PW'(r_x) : arma_pkg::sat_pred(QW'(ar_rnd));
        resid_val = arma_pkg::sat_pred(QW'(r_x) - QW'(ar_val));
        ma_rnd    = arma_pkg::round_q12(r_acc_ma);
        fin_val   = arma_pkg::sat_pred(QW'(r_ar_pred) - QW'(ma_rnd));
        sq        = r_prod[arma_pkg::SQ_W-1:0];
        total_sum = {1'b0, r_total} + (TW + 1)'(sq);
        n_total   = total_sum[TW] ? '1 : total_sum[TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x      <= i_sample;
            r_first  <= i_first;
            r_acc_ar <= '0;
            r_acc_ma <= '0;
        end else begin
            if (i_cmd.acc_ar_en) begin
                r_acc_ar <= r_acc_ar + r_prod[AW-1:0];
            end
            if (i_cmd.acc_ma_en) begin
                r_acc_ma <= r_acc_ma + r_prod[AW-1:0];
            end
        end
        if (i_cmd.ar_latch) begin
            r_ar_pred <= ar_val;
            r_resid   <= resid_val;
        end
        if (i_cmd.fin_latch) begin
            r_fin  <= fin_val;
            r_diff <= MW'(fin_val) - MW'(r_x);
        end
    end

    // histories and error total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_samp_hist[i] <= '0;
                r_res_hist[i]  <= '0;
            end
        end else if (i_cmd.start && i_first) begin
            r_total <= '0;
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_samp_hist[i] <= '0;
                r_res_hist[i]  <= '0;
            end
        end else if (i_cmd.commit) begin
            r_total        <= n_total;
            r_samp_hist[0] <= r_x;
            r_res_hist[0]  <= r_resid;
            for (int i = 1; i < MAX_ORDER; i++) begin
                r_samp_hist[i] <= r_samp_hist[i-1];
                r_res_hist[i]  <= r_res_hist[i-1];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= arma_pkg::OUT_W'({n_total, r_fin, r_resid, r_ar_pred});
        end
    end

    assign o_status.out_busy = r_out_valid && !i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out_data;

endmodule

>>> src/arma_one_step_predictor_unit.sv
// A request taken in IDLE steps through MAC, MA_LAST, FIN, SQ and COMMIT, which waits
// while the output is stalled; no new request is taken before COMMIT. One shared multiplier
// runs the three AR taps, the three MA taps and the squared error in turn.
// A finished result waits in the output register while the next request is taken.
// Reset (i_rst_n low, synchronous): orders to 1, coefficients, histories and error
// total to zero, no result pending.
// ============================================================================
// ARMA one-step predictor
// Top level: streaming ports, configuration port, controller and datapath.
// ============================================================================
module arma_one_step_predictor_unit #(
    parameter int MAX_ORDER = arma_pkg::MAX_ORDER_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [arma_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [arma_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [arma_pkg::SAMPLE_W-1:0]       i_s_tdata,  // [15:0] sample
    input  logic                                i_s_tuser,  // [0] start_of_series
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [19:0] ar_prediction, [39:20] residual, [59:40] final_prediction,
    // [107:60] error_sum, [111:108] zero
    output logic [arma_pkg::OUT_W-1:0]          o_m_tdata
);

    arma_pkg::t_dp_cmd    cmd;
    arma_pkg::t_dp_status status;

    arma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    arma_dp #(
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_sample   (signed'(i_s_tdata)),
        .i_first    (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while previous one still in work");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !status.out_busy)
        else $error("result committed over a pending output");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> o_s_tready)
        else $error("result shown before controller returned to idle");

    a_acc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.acc_ar_en && cmd.acc_ma_en))
        else $error("both accumulators enabled in one cycle");

endmodule

>>> test/arma_one_step_predictor_unit_tb.sv
// ============================================================================
// ARMA one-step predictor testbench
// Streams signed samples through the predictor with random gaps and output
// stalls. A local model tracks the sample and residual histories, the tap
// settings and the saturating squared-error total, and checks every result in
// order. Covers reset defaults, order zero, extreme coefficients, a long series
// that saturates the error total, a full-pipeline output stall, and random
// tap settings with random series.
// ============================================================================
module arma_one_step_predictor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PRED_HI = 524287;
    localparam longint PRED_LO = -524288;
    localparam logic [63:0] TOTAL_SAT = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [arma_pkg::PRED_W-1:0] ar_pred;
        logic signed [arma_pkg::PRED_W-1:0] resid;
        logic signed [arma_pkg::PRED_W-1:0] fin;
        logic [arma_pkg::SUM_W-1:0]         err;
    } t_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [arma_pkg::CFG_IDX_W-1:0]  i_cfg_idx = arma_pkg::CFG_AR_ORDER;
    logic [arma_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    logic [arma_pkg::SAMPLE_W-1:0]   i_s_tdata = '0;  // [15:0] sample
    logic                      i_s_tuser = 1'b0;  // [0] start_of_series
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    // [19:0] ar_prediction, [39:20] residual, [59:40] final_prediction,
    // [107:60] error_sum
    logic [arma_pkg::OUT_W-1:0]      o_m_tdata;

    logic [1:0]                cfg_ar_order;
    logic [1:0]                cfg_ma_order;
    logic signed [arma_pkg::COEF_W-1:0]   cfg_ar_coef [3];
    logic signed [arma_pkg::COEF_W-1:0]   cfg_ma_coef [3];
    logic signed [arma_pkg::SAMPLE_W-1:0] hist_sample [3];
    logic signed [arma_pkg::PRED_W-1:0]   hist_resid [3];
    logic [arma_pkg::SUM_W-1:0]           err_total;

    t_result                   pending_results [$];
    t_result                   want_result;

    bit                        idle_on = 1'b1;
    int                        hold_request = 0;
    int                        hold_cycles = 0;
    int                        errors = 0;
    int                        items_sent = 0;
    int                        results_seen = 0;
    int                        series_count = 0;
    int                        settings_count = 0;
    int                        total_sat_hits = 0;

    arma_one_step_predictor_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

    function automatic longint round_half_up(input longint acc);
        return (acc + 64'sd2048) >>> 12;
    endfunction

    function automatic longint clamp_pred(input longint v);
        if (v > PRED_HI) begin
            return PRED_HI;
        end else if (v < PRED_LO) begin
            return PRED_LO;
        end
        return v;
    endfunction

    function automatic t_result predict_sample(
        input logic signed [arma_pkg::SAMPLE_W-1:0] x,
        input logic first);
        longint  acc;
        longint  ar_pred;
        longint  resid;
        longint  corr;
        longint  fin;
        longint  diff;
        logic [63:0] sq;
        t_result r;
        if (first) begin
            for (int j = 0; j < 3; j++) begin
                hist_sample[j] = '0;
                hist_resid[j] = '0;
            end
            err_total = '0;
        end
        if (first) begin
            ar_pred = longint'(x);
        end else begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                if (j < int'(cfg_ar_order)) begin
                    acc += longint'(cfg_ar_coef[j]) * longint'(hist_sample[j]);
                end
            end
            ar_pred = clamp_pred(round_half_up(acc));
        end
        resid = clamp_pred(longint'(x) - ar_pred);
        acc = 0;
        for (int j = 0; j < 3; j++) begin
            if (j < int'(cfg_ma_order)) begin
                acc += longint'(cfg_ma_coef[j]) * longint'(hist_resid[j]);
            end
        end
        corr = first ? 0 : round_half_up(acc);
        fin = clamp_pred(ar_pred - corr);
        diff = fin - longint'(x);
        sq = 64'(diff * diff);
        if (sq > TOTAL_SAT - {16'b0, err_total}) begin
            err_total = TOTAL_SAT[arma_pkg::SUM_W-1:0];
        end else begin
            err_total = err_total + sq[arma_pkg::SUM_W-1:0];
        end
        for (int j = 2; j > 0; j--) begin
            hist_sample[j] = hist_sample[j-1];
            hist_resid[j] = hist_resid[j-1];
        end
        hist_sample[0] = x;
        hist_resid[0] = resid[arma_pkg::PRED_W-1:0];
        r.ar_pred = ar_pred[arma_pkg::PRED_W-1:0];
        r.resid = resid[arma_pkg::PRED_W-1:0];
        r.fin = fin[arma_pkg::PRED_W-1:0];
        r.err = err_total;
        return r;
    endfunction

    function automatic logic signed [arma_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(128)) - 64);
            3: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [arma_pkg::COEF_W-1:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return '0;
            3: return 16'($signed($urandom_range(8192)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // Order registers get junk in the unused upper bits.
    task automatic put_reg(input arma_pkg::t_cfg_reg idx,
                           input logic [arma_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings();
        put_reg(arma_pkg::CFG_AR_ORDER, {14'($urandom), cfg_ar_order});
        put_reg(arma_pkg::CFG_MA_ORDER, {14'($urandom), cfg_ma_order});
        put_reg(arma_pkg::CFG_AR_COEF_A, cfg_ar_coef[0]);
        put_reg(arma_pkg::CFG_AR_COEF_B, cfg_ar_coef[1]);
        put_reg(arma_pkg::CFG_AR_COEF_C, cfg_ar_coef[2]);
        put_reg(arma_pkg::CFG_MA_COEF_A, cfg_ma_coef[0]);
        put_reg(arma_pkg::CFG_MA_COEF_B, cfg_ma_coef[1]);
        put_reg(arma_pkg::CFG_MA_COEF_C, cfg_ma_coef[2]);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings_count++;
    endtask

    task automatic randomize_settings();
        cfg_ar_order = 2'($urandom_range(3));
        cfg_ma_order = 2'($urandom_range(3));
        for (int j = 0; j < 3; j++) begin
            cfg_ar_coef[j] = pick_coef();
            cfg_ma_coef[j] = pick_coef();
        end
    endtask

    task automatic send_sample(input logic signed [arma_pkg::SAMPLE_W-1:0] x,
                               input logic first);
        while (idle_on && $urandom_range(99) < 17) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= x;
        i_s_tuser <= first;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        pending_results.insert(pending_results.size(), predict_sample(x, first));
        items_sent++;
        if (first) begin
            series_count++;
        end
    endtask

    task automatic wait_results_done();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic test_reset_state();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        wait_results_done();
    endtask

    task automatic test_order_zero();
        cfg_ar_order = '0;
        cfg_ma_order = '0;
        for (int j = 0; j < 3; j++) begin
            cfg_ar_coef[j] = 16'sh1000;
            cfg_ma_coef[j] = -16'sh1000;
        end
        load_settings();
        send_sample(16'sd1234, 1'b1);
        send_sample(-16'sd500, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        wait_results_done();
    endtask

    task automatic test_coef_extremes();
        cfg_ar_order = 2'd3;
        cfg_ma_order = 2'd3;
        for (int j = 0; j < 3; j++) begin
            cfg_ar_coef[j] = 16'sh8000;
            cfg_ma_coef[j] = 16'sh7FFF;
        end
        load_settings();
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        wait_results_done();
        for (int j = 0; j < 3; j++) begin
            cfg_ar_coef[j] = 16'sh7FFF;
            cfg_ma_coef[j] = 16'sh8000;
        end
        load_settings();
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);
        wait_results_done();
    endtask

    // Keep the final prediction pinned high against very negative samples.
    task automatic test_error_total_saturation();
        logic signed [arma_pkg::SAMPLE_W-1:0] x;
        cfg_ar_order = 2'd3;
        cfg_ma_order = 2'd1;
        for (int j = 0; j < 3; j++) begin
            cfg_ar_coef[j] = 16'sh8000;
            cfg_ma_coef[j] = '0;
        end
        load_settings();
        send_sample(16'sh8000, 1'b1);
        for (int n = 0; n < 950; n++) begin
            if ($urandom_range(3) == 0) begin
                x = 16'($signed($urandom_range(12767)) - 32768);
            end else begin
                x = 16'sh8000;
            end
            send_sample(x, 1'b0);
        end
        wait_results_done();
    endtask

    task automatic test_output_backpressure();
        randomize_settings();
        load_settings();
        idle_on = 1'b0;
        hold_request = 300;
        send_sample(pick_sample(), 1'b1);
        for (int n = 0; n < 123; n++) begin
            send_sample(pick_sample(), $urandom_range(24) == 0);
        end
        idle_on = 1'b1;
        wait_results_done();
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 8; p++) begin
            randomize_settings();
            load_settings();
            send_sample(pick_sample(), $urandom_range(3) != 0);
            for (int n = 0; n < 99; n++) begin
                send_sample(pick_sample(), $urandom_range(24) == 0);
            end
            wait_results_done();
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_cycles = hold_request;
            hold_request = 0;
        end
        if (hold_cycles > 0) begin
            i_m_tready <= 1'b0;
            hold_cycles--;
        end else if (idle_on) begin
            i_m_tready <= ($urandom_range(99) >= 17);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result expected none, got %h", $time, o_m_tdata);
            end else begin
                want_result = pending_results.pop_front();
                results_seen++;
                if (want_result.err == TOTAL_SAT[arma_pkg::SUM_W-1:0]) begin
                    total_sat_hits++;
                end
                check_field("ar_prediction", longint'(want_result.ar_pred),
                            longint'($signed(o_m_tdata[19:0])));
                check_field("residual", longint'(want_result.resid),
                            longint'($signed(o_m_tdata[39:20])));
                check_field("final_prediction", longint'(want_result.fin),
                            longint'($signed(o_m_tdata[59:40])));
                check_field("error_sum", longint'(want_result.err),
                            longint'(o_m_tdata[107:60]));
            end
        end
    end

    initial begin
        cfg_ar_order = 2'd1;
        cfg_ma_order = 2'd1;
        for (int j = 0; j < 3; j++) begin
            cfg_ar_coef[j] = '0;
            cfg_ma_coef[j] = '0;
            hist_sample[j] = '0;
            hist_resid[j] = '0;
        end
        err_total = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_order_zero();
        test_coef_extremes();
        test_error_total_saturation();
        test_output_backpressure();
        test_random_settings();
        wait_results_done();
        $display("Streamed %0d samples over %0d series under %0d tap settings;",
                 items_sent, series_count, settings_count);
        $display("%0d results checked, error total held at saturation on %0d results.",
                 results_seen, total_sat_hits);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
